@@ rtl/ptm_pkg.sv @@
// Shared types, constants and codes for the Sv32 page table mapper.
// Has no dependencies; every other file of the block imports it.
package ptm_pkg;

  localparam int NUM_PAGES_DEF  = 64;
  localparam int PAGE_BYTES     = 4096;
  localparam int WORDS_PER_PAGE = PAGE_BYTES / 4;
  localparam int PG_OFF_W       = $clog2(WORDS_PER_PAGE);
  localparam int PPN_W          = 20;
  localparam int CNT_W          = 7;
  localparam int OP_W           = 2;
  localparam int STS_W          = 3;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [STS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STS_W-1:0] STS_VADDR   = 3'd1;
  localparam logic [STS_W-1:0] STS_PADDR   = 3'd2;
  localparam logic [STS_W-1:0] STS_NOMEM   = 3'd3;
  localparam logic [STS_W-1:0] STS_OUTSIDE = 3'd4;

  localparam logic REG_FREE_BASE = 1'b0;
  localparam logic REG_FREE_END  = 1'b1;

  localparam logic [PPN_W-1:0] FREE_BASE_RST = 20'd0;
  localparam logic [PPN_W-1:0] FREE_END_RST  = 20'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_L1_WAIT,
    S_RD_WAIT,
    S_CLEAR,
    S_LINK,
    S_LEAF
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] page_count;
    logic [PPN_W-1:0] root_ppn;
    logic [31:0]      vaddr;
    logic [31:0]      paddr;
    logic [7:0]       flags;
    logic [31:0]      read_addr;
  } req_t;

  typedef struct packed {
    logic [PPN_W-1:0] alloc_ppn;
    logic [31:0]      read_data;
    logic [STS_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic [PPN_W-1:0] free_base_ppn;
    logic [PPN_W-1:0] free_end_ppn;
  } cfg_t;

endpackage

@@ rtl/ptm_store.sv @@
// Page store: single-port synchronous RAM holding NUM_PAGES pages of words.
// Depends on ptm_pkg for the page geometry.
module ptm_store #(
  parameter int NUM_PAGES = ptm_pkg::NUM_PAGES_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 we_i,
  input  logic                                                 re_i,
  input  logic [$clog2(NUM_PAGES)+ptm_pkg::PG_OFF_W-1:0]       addr_i,
  input  logic [31:0]                                          wdata_i,
  output logic [31:0]                                          rdata_o
);
  import ptm_pkg::*;

  localparam int DEPTH = NUM_PAGES * WORDS_PER_PAGE;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptm_ctrl.sv @@
// Request sequencer: checks, page allocation, clearing and table walks.
// Depends on ptm_pkg; drives the port of ptm_store.
module ptm_ctrl #(
  parameter int NUM_PAGES = ptm_pkg::NUM_PAGES_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start,
  output logic                                           busy,
  input  ptm_pkg::req_t                                  req_i,
  input  ptm_pkg::cfg_t                                  cfg_i,
  output logic                                           res_valid_o,
  output ptm_pkg::res_t                                  res_o,
  output logic                                           mem_we_o,
  output logic                                           mem_re_o,
  output logic [$clog2(NUM_PAGES)+ptm_pkg::PG_OFF_W-1:0] mem_addr_o,
  output logic [31:0]                                    mem_wdata_o,
  input  logic [31:0]                                    mem_rdata_i
);
  import ptm_pkg::*;

  localparam int PW = $clog2(NUM_PAGES);
  localparam int AW = PW + 1;
  localparam int IW = PW + PG_OFF_W;
  localparam int CW = AW + PG_OFF_W;
  localparam int TW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [AW-1:0]    alloc_q, alloc_d;
  logic [CW-1:0]    clr_q, clr_d;
  logic [CW-1:0]    clr_end_q, clr_end_d;
  logic [IW-1:0]    l1_idx_q, l1_idx_d;
  logic [PW-1:0]    tbl_q, tbl_d;
  logic [PPN_W-1:0] tbl_ppn_q, tbl_ppn_d;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic [TW-1:0]    need;
  logic [TW-1:0]    total;
  logic             can_alloc;
  logic [21:0]      chk_ppn;
  logic [21:0]      chk_diff;
  logic             in_store;
  logic [PW-1:0]    pg_off;
  logic             va_ok;
  logic             pa_ok;
  logic             clr_last;
  logic [CW-1:0]    clr_nxt;
  logic [31:0]      leaf_pte;

  always_comb begin
    need      = (req_q.op == OP_ALLOC) ? TW'(req_q.page_count) : TW'(1);
    total     = TW'(alloc_q) + need;
    can_alloc = (total <= TW'(NUM_PAGES)) &&
                ((21'(cfg_i.free_base_ppn) + 21'(total)) <= 21'(cfg_i.free_end_ppn));
    if (state_q == S_L1_WAIT) begin
      chk_ppn = mem_rdata_i[31:10];
    end else if (req_q.op == OP_READ) begin
      chk_ppn = {2'b00, req_q.read_addr[31:12]};
    end else begin
      chk_ppn = {2'b00, req_q.root_ppn};
    end
    chk_diff = chk_ppn - {2'b00, cfg_i.free_base_ppn};
    in_store = (chk_ppn >= {2'b00, cfg_i.free_base_ppn}) && (chk_diff < 22'(NUM_PAGES));
    pg_off   = chk_diff[PW-1:0];
    va_ok    = (req_q.vaddr[11:0] == 12'd0);
    pa_ok    = (req_q.paddr[11:0] == 12'd0);
    clr_nxt  = clr_q + CW'(1);
    clr_last = (clr_nxt == clr_end_q);
    leaf_pte = {2'b00, req_q.paddr[31:12], 2'b00, req_q.flags | 8'h01};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (req_q.op)
          OP_ALLOC: begin
            state_d = (can_alloc && (req_q.page_count != '0)) ? S_CLEAR : S_IDLE;
          end
          OP_MAP: begin
            state_d = (va_ok && pa_ok && in_store) ? S_L1_WAIT : S_IDLE;
          end
          OP_READ: begin
            state_d = in_store ? S_RD_WAIT : S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_L1_WAIT: begin
        state_d = (!mem_rdata_i[0] && can_alloc) ? S_CLEAR : S_IDLE;
      end
      S_RD_WAIT: begin
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        if (clr_last) begin
          state_d = (req_q.op == OP_MAP) ? S_LINK : S_IDLE;
        end
      end
      S_LINK: begin
        state_d = S_LEAF;
      end
      S_LEAF: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_d       = req_q;
    alloc_d     = alloc_q;
    clr_d       = clr_q;
    clr_end_d   = clr_end_q;
    l1_idx_d    = l1_idx_q;
    tbl_d       = tbl_q;
    tbl_ppn_d   = tbl_ppn_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = clr_q[IW-1:0];
    mem_wdata_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
        end
      end
      S_DECODE: begin
        res_d = '0;
        unique case (req_q.op)
          OP_ALLOC: begin
            if (!can_alloc) begin
              res_d.status = STS_NOMEM;
              res_valid_d  = 1'b1;
            end else begin
              res_d.alloc_ppn = cfg_i.free_base_ppn + PPN_W'(alloc_q);
              alloc_d         = AW'(total);
              clr_d           = {alloc_q, {PG_OFF_W{1'b0}}};
              clr_end_d       = {total[AW-1:0], {PG_OFF_W{1'b0}}};
              res_valid_d     = (req_q.page_count == '0);
            end
          end
          OP_MAP: begin
            if (!va_ok) begin
              res_d.status = STS_VADDR;
              res_valid_d  = 1'b1;
            end else if (!pa_ok) begin
              res_d.status = STS_PADDR;
              res_valid_d  = 1'b1;
            end else if (!in_store) begin
              res_d.status = STS_OUTSIDE;
              res_valid_d  = 1'b1;
            end else begin
              mem_re_o   = 1'b1;
              mem_addr_o = {pg_off, req_q.vaddr[31:22]};
              l1_idx_d   = {pg_off, req_q.vaddr[31:22]};
            end
          end
          OP_READ: begin
            if (!in_store) begin
              res_d.status = STS_OUTSIDE;
              res_valid_d  = 1'b1;
            end else begin
              mem_re_o   = 1'b1;
              mem_addr_o = {pg_off, req_q.read_addr[11:2]};
            end
          end
          default: begin
            res_valid_d = 1'b1;
          end
        endcase
      end
      S_L1_WAIT: begin
        if (mem_rdata_i[0]) begin
          res_valid_d = 1'b1;
          if (!in_store) begin
            res_d.status = STS_OUTSIDE;
          end else begin
            mem_we_o    = 1'b1;
            mem_addr_o  = {pg_off, req_q.vaddr[21:12]};
            mem_wdata_o = leaf_pte;
          end
        end else if (!can_alloc) begin
          res_d.status = STS_NOMEM;
          res_valid_d  = 1'b1;
        end else begin
          tbl_d     = alloc_q[PW-1:0];
          tbl_ppn_d = cfg_i.free_base_ppn + PPN_W'(alloc_q);
          alloc_d   = AW'(total);
          clr_d     = {alloc_q, {PG_OFF_W{1'b0}}};
          clr_end_d = {total[AW-1:0], {PG_OFF_W{1'b0}}};
        end
      end
      S_RD_WAIT: begin
        res_d.read_data = mem_rdata_i;
        res_valid_d     = 1'b1;
      end
      S_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q[IW-1:0];
        clr_d      = clr_nxt;
        if (clr_last && (req_q.op == OP_ALLOC)) begin
          res_valid_d = 1'b1;
        end
      end
      S_LINK: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = l1_idx_q;
        mem_wdata_o = {2'b00, tbl_ppn_q, 9'd0, 1'b1};
      end
      S_LEAF: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = {tbl_q, req_q.vaddr[21:12]};
        mem_wdata_o = leaf_pte;
        res_valid_d = 1'b1;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alloc_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alloc_q     <= alloc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    clr_q     <= clr_d;
    clr_end_q <= clr_end_d;
    l1_idx_q  <= l1_idx_d;
    tbl_q     <= tbl_d;
    tbl_ppn_q <= tbl_ppn_d;
    res_q     <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/sv32_page_table_mapper.sv @@
// Top level of the Sv32 page table mapper: APB registers, sequencer and page store.
// Depends on ptm_pkg, ptm_ctrl and ptm_store.
//
// A request is taken when start is high and busy is low; each request gives exactly
// one result, shown for a single cycle with res_valid_o, and the receiver cannot
// stall it. All table state lives in one single-port page store of NUM_PAGES * 1024
// words, so each step makes at most one store access per cycle. An error, an unknown
// op or a zero-page alloc is answered from the decode step; a read or a map into an
// existing table first reads the store, and an alloc answers once its pages are
// cleared. A map that creates a new second-level table reads the first-level entry,
// clears the new table one word per cycle, links it and then writes the leaf. The
// store needs no clearing after reset. Registers are to be written over APB only
// while busy is low and no result is pending; the block itself does not enforce this.
module sv32_page_table_mapper #(
  parameter int NUM_PAGES = ptm_pkg::NUM_PAGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  ptm_pkg::req_t                      req_i,
  output logic                               res_valid_o,
  output ptm_pkg::res_t                      res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ptm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ptm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import ptm_pkg::*;

  localparam int IW = $clog2(NUM_PAGES) + PG_OFF_W;

  cfg_t          cfg_q, cfg_d;
  logic          cfg_wr;
  logic          mem_we;
  logic          mem_re;
  logic [IW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_FREE_BASE: cfg_d.free_base_ppn = pwdata[PPN_W-1:0];
        REG_FREE_END:  cfg_d.free_end_ppn  = pwdata[PPN_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FREE_BASE: prdata = APB_DATA_W'(cfg_q.free_base_ppn);
      REG_FREE_END:  prdata = APB_DATA_W'(cfg_q.free_end_ppn);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.free_base_ppn <= FREE_BASE_RST;
      cfg_q.free_end_ppn  <= FREE_END_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ptm_ctrl #(
    .NUM_PAGES(NUM_PAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  ptm_store #(
    .NUM_PAGES(NUM_PAGES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

@@ rtl/ptm_checker.sv @@
// Port-level checks of the page table mapper, bound to the top level.
// Depends on ptm_pkg and sv32_page_table_mapper.
module ptm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          res_valid_o,
  input ptm_pkg::res_t res_o
);
  import ptm_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a request");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != STS_OK)) |->
      ((res_o.alloc_ppn == '0) && (res_o.read_data == '0) &&
       ((res_o.status == STS_VADDR) || (res_o.status == STS_PADDR) ||
        (res_o.status == STS_NOMEM) || (res_o.status == STS_OUTSIDE))))
    else $error("error result carries data or an unknown status");

endmodule

bind sv32_page_table_mapper ptm_checker u_ptm_checker (.*);
